@@ hw/rtl/cdte_pkg.sv @@
// Shared types, constants and month tables for the civil date to epoch converter.
`default_nettype none

package cdte_pkg;

    // Year bias: a multiple of 400 that makes every shifted year non-negative.
    localparam logic [16:0] YEAR_BIAS   = 17'd32800;
    localparam logic [7:0]  BIAS_ERAS   = 8'd82;
    // floor(v / 25) == (v * RECIP_25) >> RECIP_SHIFT for v < 43690
    localparam logic [12:0] RECIP_25    = 13'd5243;
    localparam int          RECIP_SHIFT = 17;
    localparam logic [8:0]  YEARS_ERA   = 9'd400;
    localparam logic [17:0] ERA_DAYS    = 18'd146097;
    localparam logic [23:0] EPOCH_SHIFT = 24'd719468;
    // Folded bias: EPOCH_SHIFT + BIAS_ERAS * ERA_DAYS
    localparam logic [25:0] DAYS_BIAS   = 26'(EPOCH_SHIFT) + 26'(BIAS_ERAS) * 26'(ERA_DAYS);
    localparam logic [8:0]  DAYS_YEAR   = 9'd365;
    localparam logic [16:0] SEC_DAY     = 17'd86400;
    localparam logic [11:0] SEC_HOUR    = 12'd3600;
    localparam logic [5:0]  SEC_MIN     = 6'd60;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_MONTH = 2'd1,
        STATUS_BAD_DAY   = 2'd2
    } status_t;

    // After the bias add and era quotient
    typedef struct packed {
        logic [16:0] ubias;
        logic [7:0]  era_q;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [16:0] tod;
        status_t     status;
    } split_t;

    // Era quotient and year of era
    typedef struct packed {
        logic [7:0]  era_q;
        logic [8:0]  yoe;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [16:0] tod;
        status_t     status;
    } era_t;

    // Day of era, day check done
    typedef struct packed {
        logic [7:0]  era_q;
        logic [17:0] doe;
        logic [16:0] tod;
        status_t     status;
    } doe_t;

    typedef struct packed {
        logic signed [24:0] days;
        logic [16:0]        tod;
        status_t            status;
    } days_t;

    function automatic logic [4:0] month_days(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd1:    len = 5'd31;
            4'd2:    len = 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the first of the month, counting from March 1
    function automatic logic [8:0] march_offset(input logic [3:0] m);
        logic [8:0] ofs;
        case (m)
            4'd3:    ofs = 9'd0;
            4'd4:    ofs = 9'd31;
            4'd5:    ofs = 9'd61;
            4'd6:    ofs = 9'd92;
            4'd7:    ofs = 9'd122;
            4'd8:    ofs = 9'd153;
            4'd9:    ofs = 9'd184;
            4'd10:   ofs = 9'd214;
            4'd11:   ofs = 9'd245;
            4'd12:   ofs = 9'd275;
            4'd1:    ofs = 9'd306;
            4'd2:    ofs = 9'd337;
            default: ofs = 9'd0;
        endcase
        return ofs;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cdte_if.sv @@
// Valid/ready channel interfaces for date input and epoch result.
`default_nettype none

interface cdte_date_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;

    modport source (output valid, year, month, day, hour, minute, second, input ready);
    modport sink   (input valid, year, month, day, hour, minute, second, output ready);
endinterface

interface cdte_epoch_if;
    logic                valid;
    logic                ready;
    logic signed [41:0]  epoch_seconds;
    logic signed [24:0]  epoch_days;
    cdte_pkg::status_t   status;

    modport source (output valid, epoch_seconds, epoch_days, status, input ready);
    modport sink   (input valid, epoch_seconds, epoch_days, status, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cdte_era.sv @@
// Stages 1-2: month check, time of day, floor split of the year into era and year of era.
`default_nettype none

module cdte_era (
    input  wire logic          clk,
    input  wire logic          rst_n,
    cdte_date_if.sink          date,
    output logic               era_valid,
    input  wire logic          era_ready,
    output cdte_pkg::era_t     era
);

    logic               a_valid_reg;
    cdte_pkg::split_t   a_reg;
    cdte_pkg::split_t   a_next;
    logic               a_ready;

    logic               b_valid_reg;
    cdte_pkg::era_t     b_reg;
    cdte_pkg::era_t     b_next;
    logic               b_ready;

    logic signed [17:0] year_adj;
    logic [17:0]        ubias_wide;
    logic [25:0]        recip_prod;
    logic [16:0]        era_years;

    assign a_ready    = !a_valid_reg || b_ready;
    assign b_ready    = !b_valid_reg || era_ready;
    assign date.ready = a_ready;

    // Stage 1: year starts in March, bias to non-negative, divide by 400
    always_comb
    begin
        year_adj   = 18'(date.year) - ((date.month <= 4'd2) ? 18'sd1 : 18'sd0);
        ubias_wide = 18'(year_adj) + 18'(cdte_pkg::YEAR_BIAS);
        recip_prod = 26'(ubias_wide[16:4]) * 26'(cdte_pkg::RECIP_25);

        a_next.ubias  = ubias_wide[16:0];
        a_next.era_q  = recip_prod[cdte_pkg::RECIP_SHIFT +: 8];
        a_next.month  = date.month;
        a_next.day    = date.day;
        a_next.tod    = 17'(date.hour) * 17'(cdte_pkg::SEC_HOUR)
                      + 17'(date.minute) * 17'(cdte_pkg::SEC_MIN)
                      + 17'(date.second);
        a_next.status = (date.month == 4'd0 || date.month > 4'd12)
                      ? cdte_pkg::STATUS_BAD_MONTH : cdte_pkg::STATUS_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (a_ready)
            a_valid_reg <= date.valid;
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && date.valid)
            a_reg <= a_next;
    end

    // Stage 2: remainder of the biased year
    always_comb
    begin
        era_years     = 17'(a_reg.era_q) * 17'(cdte_pkg::YEARS_ERA);
        b_next.era_q  = a_reg.era_q;
        b_next.yoe    = 9'(a_reg.ubias - era_years);
        b_next.month  = a_reg.month;
        b_next.day    = a_reg.day;
        b_next.tod    = a_reg.tod;
        b_next.status = a_reg.status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (b_ready)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
            b_reg <= b_next;
    end

    assign era_valid = b_valid_reg;
    assign era       = b_reg;

endmodule

`default_nettype wire

@@ hw/rtl/cdte_days.sv @@
// Stages 3-4: leap rule and day check, day of era, then days since the epoch.
`default_nettype none

module cdte_days (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           era_valid,
    output logic                era_ready,
    input  wire cdte_pkg::era_t era,
    output logic                days_valid,
    input  wire logic           days_ready,
    output cdte_pkg::days_t     days
);

    logic               c_valid_reg;
    cdte_pkg::doe_t     c_reg;
    cdte_pkg::doe_t     c_next;
    logic               c_ready;

    logic               d_valid_reg;
    cdte_pkg::days_t    d_reg;
    cdte_pkg::days_t    d_next;
    logic               d_ready;

    logic [8:0]         cal_yoe;
    logic               leap;
    logic [4:0]         month_len;
    logic [1:0]         centuries;
    logic [17:0]        doy;
    logic [25:0]        era_days;
    logic [25:0]        days_wide;

    assign c_ready   = !c_valid_reg || d_ready;
    assign d_ready   = !d_valid_reg || days_ready;
    assign era_ready = c_ready;

    // Stage 3
    always_comb
    begin
        // January and February sit in the previous shifted year
        if (era.month <= 4'd2)
            cal_yoe = (era.yoe == 9'd399) ? 9'd0 : era.yoe + 9'd1;
        else
            cal_yoe = era.yoe;
        leap = (cal_yoe[1:0] == 2'd0) && (cal_yoe != 9'd100) && (cal_yoe != 9'd200)
            && (cal_yoe != 9'd300);
        month_len = cdte_pkg::month_days(era.month)
                  + ((era.month == 4'd2 && leap) ? 5'd1 : 5'd0);

        centuries = 2'((era.yoe >= 9'd100) ? 1 : 0) + 2'((era.yoe >= 9'd200) ? 1 : 0)
                  + 2'((era.yoe >= 9'd300) ? 1 : 0);
        doy = 18'(cdte_pkg::march_offset(era.month)) + 18'(era.day) - 18'd1;

        c_next.era_q = era.era_q;
        c_next.doe   = 18'(era.yoe) * 18'(cdte_pkg::DAYS_YEAR) + 18'(era.yoe[8:2])
                     - 18'(centuries) + doy;
        c_next.tod   = era.tod;
        if (era.status == cdte_pkg::STATUS_OK && (era.day == 5'd0 || era.day > month_len))
            c_next.status = cdte_pkg::STATUS_BAD_DAY;
        else
            c_next.status = era.status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (c_ready)
            c_valid_reg <= era_valid;
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && era_valid)
            c_reg <= c_next;
    end

    // Stage 4: result fits 25 bits signed, so modular math is exact
    always_comb
    begin
        era_days      = 26'(c_reg.era_q) * 26'(cdte_pkg::ERA_DAYS);
        days_wide     = era_days + 26'(c_reg.doe) - cdte_pkg::DAYS_BIAS;
        d_next.days   = $signed(days_wide[24:0]);
        d_next.tod    = c_reg.tod;
        d_next.status = c_reg.status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (d_ready)
            d_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (d_ready && c_valid_reg)
            d_reg <= d_next;
    end

    assign days_valid = d_valid_reg;
    assign days       = d_reg;

endmodule

`default_nettype wire

@@ hw/rtl/cdte_secs.sv @@
// Stage 5: seconds from days and time of day, zeroing on error, output register.
`default_nettype none

module cdte_secs (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            days_valid,
    output logic                 days_ready,
    input  wire cdte_pkg::days_t days,
    cdte_epoch_if.source         epoch
);

    logic                       e_valid_reg;
    logic signed [41:0]         secs_reg;
    logic signed [41:0]         secs_next;
    logic signed [24:0]         days_reg;
    logic signed [24:0]         days_next;
    cdte_pkg::status_t          status_reg;
    logic                       e_ready;
    logic signed [41:0]         day_secs;

    assign e_ready    = !e_valid_reg || epoch.ready;
    assign days_ready = e_ready;

    always_comb
    begin
        day_secs = 42'(days.days) * $signed({25'd0, cdte_pkg::SEC_DAY});
        if (days.status == cdte_pkg::STATUS_OK)
        begin
            secs_next = day_secs + $signed({25'd0, days.tod});
            days_next = days.days;
        end
        else
        begin
            secs_next = '0;
            days_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_valid_reg <= 1'b0;
        else if (e_ready)
            e_valid_reg <= days_valid;
    end

    always_ff @(posedge clk)
    begin
        if (e_ready && days_valid)
        begin
            secs_reg   <= secs_next;
            days_reg   <= days_next;
            status_reg <= days.status;
        end
    end

    assign epoch.valid         = e_valid_reg;
    assign epoch.epoch_seconds = secs_reg;
    assign epoch.epoch_days    = days_reg;
    assign epoch.status        = status_reg;

endmodule

`default_nettype wire

@@ hw/rtl/civil_date_to_epoch_seconds_top.sv @@
// Top level: civil UTC date and time to days and seconds since 1970-01-01.
//
//   channel  dir  handshake      payload
//   date     in   valid/ready    year, month, day, hour, minute, second
//   epoch    out  valid/ready    epoch_seconds, epoch_days, status
//
// Five register stages; one date per cycle while epoch is not stalled. An accepted date
// moves through stages 1 to 5 in order and is then shown on epoch.
// Each stage holds its own valid bit and fills bubbles even while the output waits.
// date.ready drops only when all five stages are full and epoch is stalled.
// Reset clears the valid bits only; the datapath registers are not reset.
`default_nettype none

module civil_date_to_epoch_seconds_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    cdte_date_if.sink       date,
    cdte_epoch_if.source    epoch
);

    logic                   era_valid;
    logic                   era_ready;
    cdte_pkg::era_t         era;
    logic                   days_valid;
    logic                   days_ready;
    cdte_pkg::days_t        days;

    cdte_era u_era (
        .clk       (clk),
        .rst_n     (rst_n),
        .date      (date),
        .era_valid (era_valid),
        .era_ready (era_ready),
        .era       (era)
    );

    cdte_days u_days (
        .clk        (clk),
        .rst_n      (rst_n),
        .era_valid  (era_valid),
        .era_ready  (era_ready),
        .era        (era),
        .days_valid (days_valid),
        .days_ready (days_ready),
        .days       (days)
    );

    cdte_secs u_secs (
        .clk        (clk),
        .rst_n      (rst_n),
        .days_valid (days_valid),
        .days_ready (days_ready),
        .days       (days),
        .epoch      (epoch)
    );

    // Errored transactions carry zero results
    assert property (@(posedge clk) disable iff (!rst_n)
        epoch.valid && epoch.status != cdte_pkg::STATUS_OK
        |-> epoch.epoch_seconds == 42'sd0 && epoch.epoch_days == 25'sd0)
        else $error("nonzero result on error status");

    // Seconds and days agree: remainder is a time of day within 17 bits
    assert property (@(posedge clk) disable iff (!rst_n)
        epoch.valid && epoch.status == cdte_pkg::STATUS_OK
        |-> (epoch.epoch_seconds - 42'(epoch.epoch_days) * 42'sd86400) >= 42'sd0
            && (epoch.epoch_seconds - 42'(epoch.epoch_days) * 42'sd86400) < 42'sd131072)
        else $error("seconds and days disagree");

    // Input backpressure only when the output is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !date.ready |-> epoch.valid && !epoch.ready)
        else $error("input stalled with output free");

    // An accepted date, with epoch ready, shows up as a valid result
    assert property (@(posedge clk) disable iff (!rst_n)
        date.valid && date.ready && epoch.ready && $past(epoch.ready)
        |=> ##4 epoch.valid)
        else $error("pipeline lost a transaction");

endmodule

`default_nettype wire
